[rtl/sdc_pkg.sv]
// ----------------------------------------------------------------------------
// sdc_pkg: shared types and helpers for the SD SPI command core
// Holds the transaction payload structs, frame constants and the CRC7 helper.
// ----------------------------------------------------------------------------
package sdc_pkg;

  localparam int unsigned POLL_LIMIT = 9;

  localparam logic [7:0] CMD_START_BITS = 8'h40;
  localparam logic [6:0] CRC7_POLY      = 7'h09;
  localparam logic [7:0] FILL_BYTE      = 8'hFF;
  localparam logic [7:0] RESP_BUSY_MASK = 8'h80;
  localparam logic [2:0] FRAME_LEN      = 3'd6;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_RX    = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [5:0]  command_index;
    logic [31:0] argument;
    logic [2:0]  response_length;
    logic [7:0]  received_byte;
  } item_t;

  typedef struct packed {
    logic        finished;
    logic [7:0]  send_byte;
    logic [7:0]  r1_status;
    logic [31:0] response_word;
  } result_t;

  // CRC7 over the 40 header bits, MSB first; pure XOR network.
  function automatic logic [6:0] crc7_of40(input logic [39:0] head);
    logic [6:0] crc;
    logic       fb;
    crc = '0;
    for (int i = 39; i >= 0; i--) begin
      fb  = head[i] ^ crc[6];
      crc = {crc[5:0], 1'b0};
      if (fb) begin
        crc = crc ^ CRC7_POLY;
      end
    end
    return crc;
  endfunction

  // Pick frame byte idx, byte 0 being the most significant.
  function automatic logic [7:0] frame_sel(input logic [47:0] frame, input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = frame[47:40];
      3'd1:    b = frame[39:32];
      3'd2:    b = frame[31:24];
      3'd3:    b = frame[23:16];
      3'd4:    b = frame[15:8];
      3'd5:    b = frame[7:0];
      default: b = FILL_BYTE;
    endcase
    return b;
  endfunction

endpackage

[rtl/sdc_in_reg.sv]
// ----------------------------------------------------------------------------
// sdc_in_reg: input register
// Captures one accepted transaction and holds it until the engine takes it.
// ----------------------------------------------------------------------------
module sdc_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  sdc_pkg::item_t in_item,
  output logic           item_valid,
  output sdc_pkg::item_t item,
  input  logic           take
);
  import sdc_pkg::*;

  logic  valid_r;
  item_t item_r;

  assign in_ready   = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

[rtl/sdc_engine.sv]
// ----------------------------------------------------------------------------
// sdc_engine: command exchange sequencer
// Builds the frame, steps through send, poll and gather, one byte per step.
// ----------------------------------------------------------------------------
module sdc_engine (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             item_valid,
  input  sdc_pkg::item_t   item,
  input  logic             out_free,
  output logic             take,
  output logic             res_load,
  output sdc_pkg::result_t res
);
  import sdc_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SEND,
    PH_POLL,
    PH_GATHER
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [47:0] frame_r, frame_nxt;
  logic [2:0]  byte_cnt_r, byte_cnt_nxt;
  logic [3:0]  poll_cnt_r, poll_cnt_nxt;
  logic [2:0]  remain_r, remain_nxt;
  logic [7:0]  status_r, status_nxt;
  logic [31:0] accum_r, accum_nxt;

  logic        produces;
  logic [39:0] head;
  logic [2:0]  byte_inc;
  logic [3:0]  poll_inc;
  logic [2:0]  remain_dec;
  logic [31:0] accum_shift;
  logic        poll_hit;

  assign head        = {2'b01, item.command_index, item.argument};
  assign byte_inc    = byte_cnt_r + 3'd1;
  assign poll_inc    = poll_cnt_r + 4'd1;
  assign remain_dec  = remain_r - 3'd1;
  assign accum_shift = {accum_r[23:0], item.received_byte};
  assign poll_hit    = ((item.received_byte & RESP_BUSY_MASK) == 8'h00) ||
                       (poll_inc >= 4'(POLL_LIMIT));

  // Start only counts when idle; a received byte only counts when busy.
  assign produces = (item.mode == MODE_START) ? (phase_r == PH_IDLE) : (phase_r != PH_IDLE);
  assign take     = item_valid && (!produces || out_free);
  assign res_load = take && produces;

  always_comb begin
    phase_nxt    = phase_r;
    frame_nxt    = frame_r;
    byte_cnt_nxt = byte_cnt_r;
    poll_cnt_nxt = poll_cnt_r;
    remain_nxt   = remain_r;
    status_nxt   = status_r;
    accum_nxt    = accum_r;
    res          = '{finished: 1'b0, send_byte: FILL_BYTE, r1_status: 8'h00,
                     response_word: 32'h0};
    if (item.mode == MODE_START) begin
      if (phase_r == PH_IDLE) begin
        frame_nxt    = {head, crc7_of40(head), 1'b1};
        byte_cnt_nxt = 3'd0;
        poll_cnt_nxt = 4'd0;
        remain_nxt   = (item.response_length == 3'd0) ? 3'd0 : item.response_length - 3'd1;
        status_nxt   = 8'h00;
        accum_nxt    = 32'h0;
        phase_nxt    = PH_SEND;
        res.send_byte = head[39:32];
      end
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
        end
        PH_SEND: begin
          byte_cnt_nxt = byte_inc;
          if (byte_inc < FRAME_LEN) begin
            res.send_byte = frame_sel(frame_r, byte_inc);
          end else begin
            phase_nxt    = PH_POLL;
            poll_cnt_nxt = 4'd0;
          end
        end
        PH_POLL: begin
          poll_cnt_nxt = poll_inc;
          if (poll_hit) begin
            status_nxt = item.received_byte;
            accum_nxt  = 32'h0;
            if (remain_r == 3'd0) begin
              phase_nxt     = PH_IDLE;
              res.finished  = 1'b1;
              res.r1_status = item.received_byte;
            end else begin
              phase_nxt = PH_GATHER;
            end
          end
        end
        PH_GATHER: begin
          accum_nxt  = accum_shift;
          remain_nxt = remain_dec;
          if (remain_dec == 3'd0) begin
            phase_nxt         = PH_IDLE;
            res.finished      = 1'b1;
            res.r1_status     = status_r;
            res.response_word = accum_shift;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      frame_r    <= '0;
      byte_cnt_r <= '0;
      poll_cnt_r <= '0;
      remain_r   <= '0;
      status_r   <= '0;
      accum_r    <= '0;
    end else if (res_load) begin
      phase_r    <= phase_nxt;
      frame_r    <= frame_nxt;
      byte_cnt_r <= byte_cnt_nxt;
      poll_cnt_r <= poll_cnt_nxt;
      remain_r   <= remain_nxt;
      status_r   <= status_nxt;
      accum_r    <= accum_nxt;
    end
  end

`ifndef SYNTHESIS
  a_finish_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res_load && res.finished |=> phase_r == PH_IDLE)
    else $error("engine not idle after finishing");

  a_send_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_SEND |-> byte_cnt_r < FRAME_LEN)
    else $error("frame byte counter out of range in send phase");

  a_poll_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_POLL |-> poll_cnt_r < 4'(POLL_LIMIT))
    else $error("poll counter passed its limit");

  a_gather_pending: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_GATHER |-> remain_r != 3'd0)
    else $error("gather phase with nothing left to collect");

  a_dropped_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    take && !produces |=> $stable(phase_r))
    else $error("ignored transaction changed the phase");
`endif

endmodule

[rtl/sdc_out_reg.sv]
// ----------------------------------------------------------------------------
// sdc_out_reg: result register
// Holds one result transaction until the consumer takes it.
// ----------------------------------------------------------------------------
module sdc_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  sdc_pkg::result_t res,
  output logic             out_free,
  output logic             out_valid,
  input  logic             out_ready,
  output sdc_pkg::result_t out_res
);
  import sdc_pkg::*;

  logic    valid_r;
  result_t res_r;

  assign out_free  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (out_free) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

[rtl/sd_spi_command_transaction_core.sv]
// ----------------------------------------------------------------------------
// sd_spi_command_transaction_core: SD card SPI command exchange
// Sequences one command frame, response poll and response gather per command.
// ----------------------------------------------------------------------------
// Drive one transaction per SPI byte exchange. A start transaction (mode 0)
// loads the command index, argument and response length, and the result
// names the first frame byte to shift out. Each later transaction (mode 1)
// carries the byte received during the last exchange and returns the next
// byte to send: the rest of the six-byte frame (0x40|cmd, argument MSB
// first, CRC7 with end bit), then 0xFF fill while the R1 byte is polled
// (up to POLL_LIMIT polls), then while trailing response bytes are gathered.
// The final result has finished set, with R1 and the gathered word. A start
// while busy, or a received byte while idle, is dropped with no result.
// Throughput is one transaction per clock while the result register can
// take a new result; a result passes from the input register to the result
// register, those being the only stages. The CRC7 is a flat XOR network
// evaluated in the same single pass.
// ----------------------------------------------------------------------------
module sd_spi_command_transaction_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [5:0]  in_command_index,
  input  logic [31:0] in_argument,
  input  logic [2:0]  in_response_length,
  input  logic [7:0]  in_received_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_finished,
  output logic [7:0]  out_send_byte,
  output logic [7:0]  out_r1_status,
  output logic [31:0] out_response_word
);
  import sdc_pkg::*;

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    take;
  logic    res_load;
  logic    out_free;
  result_t res;
  result_t out_res;

  // Bundle the input ports into one transaction word.
  assign in_item = '{mode: in_mode, command_index: in_command_index, argument: in_argument,
                     response_length: in_response_length, received_byte: in_received_byte};

  // Hold the accepted transaction until the engine can retire it.
  sdc_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .take       (take)
  );

  // Advance the exchange state and form the result in a single pass.
  sdc_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .out_free   (out_free),
    .take       (take),
    .res_load   (res_load),
    .res        (res)
  );

  // Park the result until the consumer takes it; while it waits, a transaction that would produce a result is held.
  sdc_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_load),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_finished      = out_res.finished;
  assign out_send_byte     = out_res.send_byte;
  assign out_r1_status     = out_res.r1_status;
  assign out_response_word = out_res.response_word;

endmodule
